### rtl/core/tpms_pkg.sv
package tpms_pkg;

    // field widths
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned PRE_W   = 9;
    localparam int unsigned MATCH_W = 17;
    localparam int unsigned REM_W   = 16;

    // search limits
    localparam int unsigned MATCH_MAX    = 65536;
    localparam int unsigned PRESCALE_MAX = 256;
    // counts at or above this have no qualifying candidate
    localparam int unsigned LARGE_LIMIT  = MATCH_MAX * (PRESCALE_MAX + 1);

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic norm;
        logic advance;
        logic exact;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic direct;
        logic no_fit;
        logic r_ge_d;
        logic q_over;
        logic r_zero;
        logic out_free;
    } t_status;

endpackage

### rtl/core/tpms_if.sv
// input channel: one tick count per transaction
interface tpms_in_if;
    import tpms_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] tick_count;

    modport source (output valid, output tick_count, input ready);
    modport sink   (input valid, input tick_count, output ready);
endinterface

// result channel: prescale and match value per transaction
interface tpms_out_if;
    import tpms_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRE_W-1:0]   prescale;
    logic [MATCH_W-1:0] match_value;

    modport source (output valid, output prescale, output match_value, input ready);
    modport sink   (input valid, input prescale, input match_value, output ready);
endinterface

### rtl/core/timer_prescale_match_search_unit.sv
// channel  | dir | payload                         | handshake
// i_tick   | in  | tick_count[31:0]                | valid/ready
// o_res    | out | prescale[8:0], match_value[16:0] | valid/ready
//
// counts up to 65536, and counts with no qualifying candidate, skip the search.
// other counts search one divisor per cycle from 65536 downward while no fold is due;
// each time the running remainder is folded back below the divisor, the fold is a step
// of its own; the search ends at an exact divisor or once the quotient passes 256.
// synchronous active-low reset clears the controller and the result valid.
// a new tick count is taken while an earlier result still waits in the output register;
// a stalled output holds the finished search until the register frees.
module timer_prescale_match_search_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpms_in_if.sink     i_tick,
    tpms_out_if.source  o_res
);
    import tpms_pkg::*;

    t_cmd    cmd;
    t_status status;

    tpms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .i_status   (status),
        .o_in_ready (i_tick.ready),
        .o_cmd      (cmd)
    );

    tpms_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_count  (i_tick.tick_count),
        .i_cmd         (cmd),
        .i_out_ready   (o_res.ready),
        .o_status      (status),
        .o_valid       (o_res.valid),
        .o_prescale    (o_res.prescale),
        .o_match_value (o_res.match_value)
    );

endmodule

### rtl/core/tpms_datapath.sv
module tpms_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tpms_pkg::COUNT_W-1:0]   i_tick_count,
    input  tpms_pkg::t_cmd                 i_cmd,
    input  logic                           i_out_ready,
    output tpms_pkg::t_status              o_status,
    output logic                           o_valid,
    output logic [tpms_pkg::PRE_W-1:0]     o_prescale,
    output logic [tpms_pkg::MATCH_W-1:0]   o_match_value
);
    import tpms_pkg::*;

    // running division state: count = r_q * r_d + r_r
    logic [MATCH_W-1:0] r_d;
    logic [PRE_W-1:0]   r_q;
    logic [MATCH_W-1:0] r_r;
    logic               r_first;

    // best candidate so far
    logic [PRE_W-1:0]   r_best_pre;
    logic [MATCH_W-1:0] r_best_match;
    logic [REM_W-1:0]   r_best_rem;

    // result register
    logic               r_out_valid;
    logic [PRE_W-1:0]   r_out_pre;
    logic [MATCH_W-1:0] r_out_match;

    logic               better;

    assign better = r_first || (r_r[REM_W-1:0] < r_best_rem);

    // search datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= 1'b1;
            r_d     <= MATCH_W'(MATCH_MAX);
            // quotient and remainder for the top candidate
            r_q     <= i_tick_count[REM_W +: PRE_W];
            r_r     <= {1'b0, i_tick_count[REM_W-1:0]};
            r_best_pre <= PRE_W'(1);
            if (o_status.direct) begin
                r_best_match <= i_tick_count[MATCH_W-1:0];
            end else begin
                r_best_match <= MATCH_W'(MATCH_MAX);
            end
        end
        // fold remainder back below the divisor
        if (i_cmd.norm) begin
            r_r <= r_r - r_d;
            r_q <= r_q + PRE_W'(1);
        end
        // exact divisor wins at once
        if (i_cmd.exact) begin
            r_best_pre   <= r_q;
            r_best_match <= r_d;
        end
        // record candidate, then step to the next lower divisor
        if (i_cmd.advance) begin
            if (better) begin
                r_best_rem   <= r_r[REM_W-1:0];
                r_best_pre   <= r_q;
                r_best_match <= r_d;
            end
            r_first <= 1'b0;
            r_d     <= r_d - MATCH_W'(1);
            r_r     <= r_r + MATCH_W'(r_q);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pre   <= r_best_pre;
            r_out_match <= r_best_match;
        end
    end

    // status to controller
    always_comb begin
        o_status.direct   = i_tick_count <= COUNT_W'(MATCH_MAX);
        o_status.no_fit   = i_tick_count >= COUNT_W'(LARGE_LIMIT);
        o_status.r_ge_d   = r_r >= r_d;
        o_status.q_over   = r_q > PRE_W'(PRESCALE_MAX);
        o_status.r_zero   = r_r == '0;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_prescale    = r_out_pre;
    assign o_match_value = r_out_match;

    // checks
    a_pre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pre != '0) && (r_out_pre <= PRE_W'(PRESCALE_MAX)))
        else $error("prescale out of range");

    a_match_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_match <= MATCH_W'(MATCH_MAX))
        else $error("match value out of range");

    a_advance_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_r < r_d) && (r_q <= PRE_W'(PRESCALE_MAX)))
        else $error("candidate recorded with unnormalized remainder");

    a_norm_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.norm |=> r_q == $past(r_q) + PRE_W'(1))
        else $error("quotient did not step on fold");

endmodule

### rtl/core/tpms_ctrl.sv
module tpms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tpms_pkg::t_status i_status,
    output logic              o_in_ready,
    output tpms_pkg::t_cmd    o_cmd
);
    import tpms_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = r_state == ST_IDLE;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.direct || i_status.no_fit) begin
                        n_state = ST_HOLD;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (i_status.r_ge_d) begin
                    o_cmd.norm = 1'b1;
                end else if (i_status.q_over) begin
                    n_state = ST_HOLD;
                end else if (i_status.r_zero) begin
                    o_cmd.exact = 1'b1;
                    n_state     = ST_HOLD;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_IDLE)
        else $error("load outside idle");

    a_trivial_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && (i_status.direct || i_status.no_fit)) |=> r_state == ST_HOLD)
        else $error("direct case did not go to hold");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command issued");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tpms_pkg::*;

    localparam int unsigned N_RANDOM    = 100;
    localparam int unsigned N_LONG      = 2;       // random mid-range counts, full-length search
    localparam int unsigned QUIET_LIMIT = 300000;  // cycles with no transaction at all
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned MAX_REPORTS = 10;

    // one pending tick count, optionally held back until the unit has drained
    typedef struct {
        logic [COUNT_W-1:0] count;
        bit                 drain_first;
    } t_tick_item;

    // prescale / match pair the unit should report
    typedef struct packed {
        logic [PRE_W-1:0]   prescale;
        logic [MATCH_W-1:0] match_value;
    } t_timer_setting;

    logic clk = 1'b0;
    logic rst_n;

    tpms_in_if  tick_if();
    tpms_out_if res_if();

    timer_prescale_match_search_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if),
        .o_res   (res_if)
    );

    t_tick_item     tick_q[$];
    t_timer_setting setting_q[$];

    int unsigned n_total;
    int unsigned n_sent;
    int unsigned n_taken;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_direct;
    int unsigned n_searched;
    int unsigned n_out_of_range;
    int unsigned n_drains;
    int unsigned quiet_cycles;

    // clock, 8 ns period
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // best prescale / match pair for a tick count
    function automatic t_timer_setting best_timer_setting(input logic [COUNT_W-1:0] ticks);
        t_timer_setting  r;
        longint unsigned n;
        longint unsigned lowest;
        longint unsigned cand;
        longint unsigned quot;
        longint unsigned rem;
        longint unsigned best_rem;
        longint unsigned best_pre;
        longint unsigned best_match;
        n          = ticks;
        best_pre   = 1;
        best_match = MATCH_MAX;
        best_rem   = n;
        if (n <= MATCH_MAX) begin
            best_match = n;
        end else begin
            // quotient stays within the prescaler only from this candidate upward
            lowest = n / (PRESCALE_MAX + 1) + 1;
            for (cand = MATCH_MAX; cand >= lowest; cand--) begin
                quot = n / cand;
                rem  = n % cand;
                if (quot <= PRESCALE_MAX) begin
                    if (rem == 0) begin
                        best_pre   = quot;
                        best_match = cand;
                        break;
                    end
                    if (rem < best_rem) begin
                        best_rem   = rem;
                        best_pre   = quot;
                        best_match = cand;
                    end
                end
            end
        end
        r.prescale    = best_pre[PRE_W-1:0];
        r.match_value = best_match[MATCH_W-1:0];
        return r;
    endfunction

    function automatic int unsigned idle_phase();
        return (n_sent * 3) / (n_total == 0 ? 1 : n_total);
    endfunction

    // tick driver, changes inputs on the falling edge
    always @(negedge clk) begin
        int unsigned idle_pct;
        idle_pct = (idle_phase() == 0) ? 28 : (idle_phase() == 1) ? 75 : 0;
        if (!rst_n) begin
            tick_if.valid      <= 1'b0;
            tick_if.tick_count <= '0;
        end else if (tick_if.valid && (n_taken != n_sent)) begin
            // transaction not yet taken, hold it
        end else if (tick_q.size() == 0 || $urandom_range(99) < idle_pct) begin
            tick_if.valid <= 1'b0;
        end else if (tick_q[0].drain_first && setting_q.size() != 0) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_q[0].drain_first)
                n_drains <= n_drains + 1;
            tick_if.valid      <= 1'b1;
            tick_if.tick_count <= tick_q[0].count;
            void'(tick_q.pop_front());
            n_sent <= n_sent + 1;
        end
    end

    // result back-pressure
    always @(negedge clk) begin
        int unsigned idle_pct;
        idle_pct = (idle_phase() == 0) ? 75 : (idle_phase() == 1) ? 28 : 0;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // monitor: predict on each accepted tick, check each accepted result
    always @(posedge clk) begin
        t_timer_setting got;
        t_timer_setting want;
        bit             moved;
        if (rst_n) begin
            moved = 1'b0;
            if (tick_if.valid && tick_if.ready) begin
                moved = 1'b1;
                setting_q.push_back(best_timer_setting(tick_if.tick_count));
                n_taken <= n_taken + 1;
                if (tick_if.tick_count <= MATCH_MAX)
                    n_direct <= n_direct + 1;
                else if (tick_if.tick_count >= LARGE_LIMIT)
                    n_out_of_range <= n_out_of_range + 1;
                else
                    n_searched <= n_searched + 1;
            end
            if (res_if.valid && res_if.ready) begin
                moved           = 1'b1;
                got.prescale    = res_if.prescale;
                got.match_value = res_if.match_value;
                n_results <= n_results + 1;
                if (setting_q.size() == 0) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: prescale %0d match %0d",
                                 $realtime, got.prescale, got.match_value);
                end else begin
                    want = setting_q.pop_front();
                    if (got.prescale !== want.prescale
                        || got.match_value !== want.match_value) begin
                        n_errors = n_errors + 1;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: mismatch: prescale %0d (exp %0d) match %0d (exp %0d)",
                                     $realtime, got.prescale, want.prescale,
                                     got.match_value, want.match_value);
                    end
                end
            end
            // watchdog on cycles with no transaction on either channel
            if (moved) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results pending",
                         QUIET_LIMIT, setting_q.size());
                $display("FAIL timer_prescale_match_search_unit");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_tick_item  it;
        int unsigned pick;
        int unsigned i;
        logic [COUNT_W-1:0] direct_counts[$];

        rst_n              = 1'b0;
        tick_if.valid      = 1'b0;
        tick_if.tick_count = '0;
        res_if.ready       = 1'b0;
        n_sent = 0; n_taken = 0; n_results = 0; n_errors = 0;
        n_direct = 0; n_searched = 0; n_out_of_range = 0; n_drains = 0;
        quiet_cycles = 0;

        // directed: field extremes, range edges, exact and inexact searches
        direct_counts = '{
            32'd0, 32'd1, 32'h0000_FFFF, MATCH_MAX,
            MATCH_MAX + 1,                   // prime, searches all the way down
            2 * MATCH_MAX, 3 * 65535, 100 * 65521,
            256 * MATCH_MAX,                 // largest prescale, exact at the top
            LARGE_LIMIT - 2, LARGE_LIMIT - 1,
            LARGE_LIMIT,                     // first count with no qualifying candidate
            32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'hFFFF_FFFF
        };
        foreach (direct_counts[k]) begin
            it.count       = direct_counts[k];
            it.drain_first = 1'b0;
            tick_q.push_back(it);
        end

        // random: mostly short searches, a few full-length ones
        for (i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(99);
            if (i < N_LONG)
                it.count = $urandom_range(LARGE_LIMIT - 1, MATCH_MAX + 1);
            else if (pick < 20)
                it.count = $urandom_range(MATCH_MAX, 0);
            else if (pick < 40)
                it.count = $urandom_range(32'hFFFF_FFFF, LARGE_LIMIT);
            else if (pick < 65)
                // exact divisor close to the top of the candidate range
                it.count = $urandom_range(MATCH_MAX, MATCH_MAX - 1000) * $urandom_range(256, 2);
            else if (pick < 90)
                // just below the out-of-range edge, short remainder search
                it.count = LARGE_LIMIT - $urandom_range(300 * 257, 1);
            else
                it.count = $urandom();
            it.drain_first = 1'b0;
            tick_q.push_back(it);
        end
        n_total = tick_q.size();

        // let the unit drain before the first random count and at the start of the second and third phases
        tick_q[direct_counts.size()].drain_first = 1'b1;
        tick_q[n_total / 3].drain_first          = 1'b1;
        tick_q[(2 * n_total) / 3].drain_first    = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_taken != n_total || setting_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d tick counts: %0d direct, %0d searched, %0d out of range",
                 n_taken, n_direct, n_searched, n_out_of_range);
        $display("%0d results compared, %0d drain pauses, %0d errors",
                 n_results, n_drains, n_errors);
        if (n_errors == 0)
            $display("PASS timer_prescale_match_search_unit");
        else
            $display("FAIL timer_prescale_match_search_unit");
        $finish;
    end

endmodule
